### sv/i2c_master_pin_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master pin sequencer assertion macros
// Shared concurrent assertion helpers, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_PIN_SEQUENCER_MACROS_SVH
`define I2C_MASTER_PIN_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// check that a implies b in the same cycle
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("i2cm assertion failed");
// check that a implies b in the next cycle
`define I2CM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master pin sequencer package
// Types, command codes, register map and reset values.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] FUNC_START    = 3'd0;
  localparam logic [2:0] FUNC_STOP     = 3'd1;
  localparam logic [2:0] FUNC_WRITE    = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;
  localparam logic [2:0] FUNC_ACK_BIT  = 3'd5;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [1:0] REG_HALF_PERIOD    = 2'd0;
  localparam logic [1:0] REG_READ_HIGH_HOLD = 2'd1;
  localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RST    = 16'd50;
  localparam logic [15:0] READ_HIGH_HOLD_RST = 16'd125;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_S1    = 4'd1,
    PH_S2    = 4'd2,
    PH_T1    = 4'd3,
    PH_T2    = 4'd4,
    PH_A1    = 4'd5,
    PH_A2    = 4'd6,
    PH_APOLL = 4'd7,
    PH_WLOW  = 4'd8,
    PH_WHIGH = 4'd9,
    PH_WTAIL = 4'd10,
    PH_RLOW  = 4'd11,
    PH_RHIGH = 4'd12,
    PH_KLOW  = 4'd13,
    PH_KHIGH = 4'd14
  } phase_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [15:0] read_high_hold;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_level;
    logic       sda_enable;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

endpackage

### sv/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Phase state registers and one-tick next-state logic.
// ----------------------------------------------------------------------------
`include "i2c_master_pin_sequencer_macros.svh"

module i2cm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  i2cm_pkg::tick_t tick,
  input  i2cm_pkg::cfg_t  cfg,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_choice_r, ack_choice_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        oe_r, oe_nxt;
  logic        fail_r, fail_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        done;
  logic [16:0] cnt_inc;
  logic        hp_over;
  logic        rh_over;
  logic [3:0]  bit_inc;

  assign cnt_inc = {1'b0, tick_r} + 17'd1;
  assign hp_over = cnt_inc >= {1'b0, cfg.half_period};
  assign rh_over = cnt_inc >= {1'b0, cfg.read_high_hold};
  assign bit_inc = bit_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_nxt        = bit_r;
    tick_nxt       = tick_r;
    poll_nxt       = poll_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    oe_nxt         = oe_r;
    fail_nxt       = fail_r;
    rx_nxt         = rx_r;
    done           = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (tick.cmd_valid && tick.func <= FUNC_ACK_BIT) begin
          tick_nxt = '0;
          case (tick.func)
            FUNC_START: begin
              oe_nxt    = 1'b1;
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b1;
              phase_nxt = PH_S1;
            end
            FUNC_STOP: begin
              oe_nxt    = 1'b1;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_T1;
            end
            FUNC_WRITE: begin
              oe_nxt    = 1'b1;
              scl_nxt   = 1'b0;
              bit_nxt   = '0;
              sda_nxt   = tick.tx_byte[7];
              shift_nxt = {tick.tx_byte[6:0], 1'b0};
              phase_nxt = PH_WLOW;
            end
            FUNC_READ: begin
              ack_choice_nxt = tick.send_ack;
              oe_nxt         = 1'b0;
              scl_nxt        = 1'b0;
              shift_nxt      = '0;
              bit_nxt        = '0;
              phase_nxt      = PH_RLOW;
            end
            FUNC_WAIT_ACK: begin
              fail_nxt  = 1'b0;
              poll_nxt  = '0;
              oe_nxt    = 1'b1;
              sda_nxt   = 1'b1;
              phase_nxt = PH_A1;
            end
            default: begin
              ack_choice_nxt = tick.send_ack;
              scl_nxt        = 1'b0;
              oe_nxt         = 1'b1;
              sda_nxt        = !tick.send_ack;
              phase_nxt      = PH_KLOW;
            end
          endcase
        end
      end
      PH_S1, PH_S2, PH_T1, PH_T2, PH_A1, PH_A2, PH_WLOW, PH_WHIGH, PH_WTAIL,
      PH_RLOW, PH_KLOW, PH_KHIGH: begin
        if (!hp_over) begin
          tick_nxt = cnt_inc[15:0];
        end else begin
          tick_nxt = '0;
          case (phase_r)
            PH_S1: begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_S2;
            end
            PH_S2: begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
            PH_T1: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_T2;
            end
            PH_T2: begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
            PH_A1: begin
              oe_nxt    = 1'b0;
              scl_nxt   = 1'b1;
              phase_nxt = PH_A2;
            end
            PH_A2: begin
              phase_nxt = PH_APOLL;
            end
            PH_WLOW: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_WHIGH;
            end
            PH_WHIGH: begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_WTAIL;
            end
            PH_WTAIL: begin
              if (bit_inc >= BITS_PER_BYTE) begin
                bit_nxt   = '0;
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                bit_nxt   = bit_inc;
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
                phase_nxt = PH_WLOW;
              end
            end
            PH_RLOW: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], tick.sda_level};
              phase_nxt = PH_RHIGH;
            end
            PH_KLOW: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_KHIGH;
            end
            default: begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          endcase
        end
      end
      PH_RHIGH: begin
        if (!rh_over) begin
          tick_nxt = cnt_inc[15:0];
        end else begin
          tick_nxt = '0;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_nxt   = '0;
            rx_nxt    = shift_r;
            scl_nxt   = 1'b0;
            oe_nxt    = 1'b1;
            sda_nxt   = !ack_choice_r;
            phase_nxt = PH_KLOW;
          end else begin
            bit_nxt   = bit_inc;
            scl_nxt   = 1'b0;
            phase_nxt = PH_RLOW;
          end
        end
      end
      PH_APOLL: begin
        if (!tick.sda_level) begin
          scl_nxt   = 1'b0;
          fail_nxt  = 1'b0;
          tick_nxt  = '0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else if (poll_r >= cfg.ack_poll_limit) begin
          fail_nxt  = 1'b1;
          oe_nxt    = 1'b1;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          tick_nxt  = '0;
          phase_nxt = PH_T1;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end
      default: begin
        tick_nxt  = '0;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.scl_level       = scl_nxt;
    res.sda_drive_level = sda_nxt;
    res.sda_enable      = oe_nxt;
    res.busy            = phase_nxt != PH_IDLE;
    res.done            = done;
    res.rx_byte         = rx_nxt;
    res.ack_failed      = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_r        <= '0;
      tick_r       <= '0;
      poll_r       <= '0;
      shift_r      <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      oe_r         <= 1'b1;
      fail_r       <= 1'b0;
      rx_r         <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_r        <= bit_nxt;
      tick_r       <= tick_nxt;
      poll_r       <= poll_nxt;
      shift_r      <= shift_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      oe_r         <= oe_nxt;
      fail_r       <= fail_nxt;
      rx_r         <= rx_nxt;
    end
  end

  `I2CM_ASSERT_IMPLIES(a_bit_range, clk, rst_n, 1'b1, bit_r < BITS_PER_BYTE)
  `I2CM_ASSERT_IMPLIES(a_idle_count_clear, clk, rst_n, phase_r == PH_IDLE, tick_r == '0)
  `I2CM_ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, res.done, !res.busy)

endmodule

### sv/i2cm_obuf.sv
// ----------------------------------------------------------------------------
// I2C master result buffer
// Output register with one skid entry between core and result channel.
// ----------------------------------------------------------------------------
`include "i2c_master_pin_sequencer_macros.svh"

module i2cm_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::res_t push_res,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output i2cm_pkg::res_t out_res
);
  import i2cm_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r && !take;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (take) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `I2CM_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `I2CM_ASSERT_NEXT(a_skid_fill_on_stall, clk, rst_n, push && out_valid_r && out_stall,
                    skid_valid_r)
  `I2CM_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall,
                    !skid_valid_r && out_valid_r)

endmodule

### sv/i2c_master_pin_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master pin sequencer
// Bit-banged I2C master: one input transaction is one bus timing tick.
// The result of a tick is registered in the result buffer before it reaches out_*.
// Throughput: one tick per cycle while in_stall is low; the phase step is a single registered pass.
// A two-entry result buffer lets input continue into its skid entry when out_stall holds the output.
// Reset: synchronous, active low; bus lines high, driving, registers default.
// ----------------------------------------------------------------------------
module i2c_master_pin_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [i2cm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [i2cm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd_valid,
  input  logic [2:0]                    in_func,
  input  logic [7:0]                    in_tx_byte,
  input  logic                          in_send_ack,
  input  logic                          in_sda_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scl_level,
  output logic                          out_sda_drive_level,
  output logic                          out_sda_enable,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [7:0]                    out_rx_byte,
  output logic                          out_ack_failed
);
  import i2cm_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  tick_t      tick;
  res_t       step_res;
  res_t       out_res;
  logic       buf_full;
  logic       accept;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_HALF_PERIOD:    cfg_nxt.half_period    = cfg_pwdata[15:0];
        REG_READ_HIGH_HOLD: cfg_nxt.read_high_hold = cfg_pwdata[15:0];
        REG_ACK_POLL_LIMIT: cfg_nxt.ack_poll_limit = cfg_pwdata[7:0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HALF_PERIOD:    cfg_prdata = {16'd0, cfg_r.half_period};
      REG_READ_HIGH_HOLD: cfg_prdata = {16'd0, cfg_r.read_high_hold};
      REG_ACK_POLL_LIMIT: cfg_prdata = {24'd0, cfg_r.ack_poll_limit};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period    <= HALF_PERIOD_RST;
      cfg_r.read_high_hold <= READ_HIGH_HOLD_RST;
      cfg_r.ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  always_comb begin
    tick.cmd_valid = in_cmd_valid;
    tick.func      = in_func;
    tick.tx_byte   = in_tx_byte;
    tick.send_ack  = in_send_ack;
    tick.sda_level = in_sda_level;
  end

  i2cm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .tick  (tick),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_scl_level       = out_res.scl_level;
  assign out_sda_drive_level = out_res.sda_drive_level;
  assign out_sda_enable      = out_res.sda_enable;
  assign out_busy_res        = out_res.busy;
  assign out_done_res        = out_res.done;
  assign out_rx_byte         = out_res.rx_byte;
  assign out_ack_failed      = out_res.ack_failed;

endmodule

### tb/i2c_master_pin_sequencer_test.sv
// ----------------------------------------------------------------------------
// I2C master pin sequencer testbench
// Streams bus timing ticks into the sequencer through the valid/stall channel
// and compares every pin/status transaction against a cycle-exact software
// copy of the sequencer kept in a small scoreboard class. Directed commands
// cover each bus operation and the byte extremes. Random command streams then
// run under several timing and ack-limit settings, including zero phase
// lengths, and a start is held at maximum phase lengths; there are random
// gaps on both channels, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module i2c_master_pin_sequencer_test;
  import i2cm_pkg::*;

  localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 40;
  localparam int MAX_PRINTS   = 40;

  class pin_scoreboard;
    logic [15:0] half_period;
    logic [15:0] read_high_hold;
    logic [7:0]  ack_poll_limit;
    phase_t      cur_phase;
    logic [3:0]  bit_pos;
    logic [15:0] tick_cnt;
    logic [7:0]  poll_cnt;
    logic [7:0]  shifter;
    logic        ack_sel;
    logic        scl_q;
    logic        sda_q;
    logic        sda_oe_q;
    logic        ack_fail_q;
    logic [7:0]  last_rx;
    res_t        expected_pins[$];
    int          errors;

    function new();
      half_period = HALF_PERIOD_RST;
      read_high_hold = READ_HIGH_HOLD_RST;
      ack_poll_limit = ACK_POLL_LIMIT_RST;
      cur_phase = PH_IDLE;
      bit_pos = '0;
      tick_cnt = '0;
      poll_cnt = '0;
      shifter = '0;
      ack_sel = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      sda_oe_q = 1'b1;
      ack_fail_q = 1'b0;
      last_rx = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_HALF_PERIOD:    half_period = val[15:0];
        REG_READ_HIGH_HOLD: read_high_hold = val[15:0];
        REG_ACK_POLL_LIMIT: ack_poll_limit = val[7:0];
        default: ;
      endcase
    endfunction

    function bit hold_over(logic [15:0] len);
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= len) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void enter(phase_t ph);
      cur_phase = ph;
      tick_cnt = '0;
    endfunction

    function void begin_stop();
      sda_oe_q = 1'b1;
      scl_q = 1'b0;
      sda_q = 1'b0;
      enter(PH_T1);
    endfunction

    function void begin_ack_bit();
      scl_q = 1'b0;
      sda_oe_q = 1'b1;
      sda_q = !ack_sel;
      enter(PH_KLOW);
    endfunction

    function void put_tx_bit();
      sda_q = shifter[7];
      shifter = {shifter[6:0], 1'b0};
    endfunction

    function res_t advance(tick_t t);
      res_t r;
      logic done;
      done = 1'b0;
      case (cur_phase)
        PH_IDLE: begin
          if (t.cmd_valid && t.func <= FUNC_ACK_BIT) begin
            case (t.func)
              FUNC_START: begin
                sda_oe_q = 1'b1;
                sda_q = 1'b1;
                scl_q = 1'b1;
                enter(PH_S1);
              end
              FUNC_STOP: begin_stop();
              FUNC_WRITE: begin
                sda_oe_q = 1'b1;
                scl_q = 1'b0;
                shifter = t.tx_byte;
                bit_pos = '0;
                put_tx_bit();
                enter(PH_WLOW);
              end
              FUNC_READ: begin
                ack_sel = t.send_ack;
                sda_oe_q = 1'b0;
                scl_q = 1'b0;
                shifter = '0;
                bit_pos = '0;
                enter(PH_RLOW);
              end
              FUNC_WAIT_ACK: begin
                ack_fail_q = 1'b0;
                poll_cnt = '0;
                sda_oe_q = 1'b1;
                sda_q = 1'b1;
                enter(PH_A1);
              end
              default: begin
                ack_sel = t.send_ack;
                begin_ack_bit();
              end
            endcase
          end
        end
        PH_S1: if (hold_over(half_period)) begin
          sda_q = 1'b0;
          enter(PH_S2);
        end
        PH_S2: if (hold_over(half_period)) begin
          scl_q = 1'b0;
          enter(PH_IDLE);
          done = 1'b1;
        end
        PH_T1: if (hold_over(half_period)) begin
          scl_q = 1'b1;
          enter(PH_T2);
        end
        PH_T2: if (hold_over(half_period)) begin
          sda_q = 1'b1;
          enter(PH_IDLE);
          done = 1'b1;
        end
        PH_A1: if (hold_over(half_period)) begin
          sda_oe_q = 1'b0;
          scl_q = 1'b1;
          enter(PH_A2);
        end
        PH_A2: if (hold_over(half_period)) begin
          enter(PH_APOLL);
        end
        PH_APOLL: begin
          if (!t.sda_level) begin
            scl_q = 1'b0;
            ack_fail_q = 1'b0;
            enter(PH_IDLE);
            done = 1'b1;
          end else if (poll_cnt >= ack_poll_limit) begin
            ack_fail_q = 1'b1;
            begin_stop();
          end else begin
            poll_cnt = poll_cnt + 8'd1;
          end
        end
        PH_WLOW: if (hold_over(half_period)) begin
          scl_q = 1'b1;
          enter(PH_WHIGH);
        end
        PH_WHIGH: if (hold_over(half_period)) begin
          scl_q = 1'b0;
          enter(PH_WTAIL);
        end
        PH_WTAIL: if (hold_over(half_period)) begin
          bit_pos = bit_pos + 4'd1;
          if (bit_pos >= BITS_PER_BYTE) begin
            bit_pos = '0;
            enter(PH_IDLE);
            done = 1'b1;
          end else begin
            put_tx_bit();
            enter(PH_WLOW);
          end
        end
        PH_RLOW: if (hold_over(half_period)) begin
          scl_q = 1'b1;
          shifter = {shifter[6:0], t.sda_level};
          enter(PH_RHIGH);
        end
        PH_RHIGH: if (hold_over(read_high_hold)) begin
          bit_pos = bit_pos + 4'd1;
          if (bit_pos >= BITS_PER_BYTE) begin
            bit_pos = '0;
            last_rx = shifter;
            begin_ack_bit();
          end else begin
            scl_q = 1'b0;
            enter(PH_RLOW);
          end
        end
        PH_KLOW: if (hold_over(half_period)) begin
          scl_q = 1'b1;
          enter(PH_KHIGH);
        end
        PH_KHIGH: if (hold_over(half_period)) begin
          scl_q = 1'b0;
          enter(PH_IDLE);
          done = 1'b1;
        end
        default: enter(PH_IDLE);
      endcase
      r.scl_level = scl_q;
      r.sda_drive_level = sda_q;
      r.sda_enable = sda_oe_q;
      r.busy = (cur_phase != PH_IDLE);
      r.done = done;
      r.rx_byte = last_rx;
      r.ack_failed = ack_fail_q;
      return r;
    endfunction

    function void note_tick(tick_t t);
      expected_pins.push_back(advance(t));
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_pins(res_t got);
      res_t exp;
      if (expected_pins.size() == 0) begin
        report("output transaction with nothing expected");
      end else begin
        exp = expected_pins.pop_front();
        if (got.scl_level !== exp.scl_level)
          report($sformatf("scl_level got %b exp %b", got.scl_level, exp.scl_level));
        if (got.sda_drive_level !== exp.sda_drive_level)
          report($sformatf("sda_drive_level got %b exp %b",
                           got.sda_drive_level, exp.sda_drive_level));
        if (got.sda_enable !== exp.sda_enable)
          report($sformatf("sda_enable got %b exp %b", got.sda_enable, exp.sda_enable));
        if (got.busy !== exp.busy)
          report($sformatf("busy_res got %b exp %b", got.busy, exp.busy));
        if (got.done !== exp.done)
          report($sformatf("done_res got %b exp %b", got.done, exp.done));
        if (got.rx_byte !== exp.rx_byte)
          report($sformatf("rx_byte got %h exp %h", got.rx_byte, exp.rx_byte));
        if (got.ack_failed !== exp.ack_failed)
          report($sformatf("ack_failed got %b exp %b", got.ack_failed, exp.ack_failed));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd_valid = 1'b0;
  logic [2:0]        in_func = '0;
  logic [7:0]        in_tx_byte = '0;
  logic              in_send_ack = 1'b0;
  logic              in_sda_level = 1'b1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_scl_level;
  logic              out_sda_drive_level;
  logic              out_sda_enable;
  logic              out_busy_res;
  logic              out_done_res;
  logic [7:0]        out_rx_byte;
  logic              out_ack_failed;

  pin_scoreboard sb = new();
  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  i2c_master_pin_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd_valid        (in_cmd_valid),
    .in_func             (in_func),
    .in_tx_byte          (in_tx_byte),
    .in_send_ack         (in_send_ack),
    .in_sda_level        (in_sda_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scl_level       (out_scl_level),
    .out_sda_drive_level (out_sda_drive_level),
    .out_sda_enable      (out_sda_enable),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_rx_byte         (out_rx_byte),
    .out_ack_failed      (out_ack_failed)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_tick({in_cmd_valid, in_func, in_tx_byte, in_send_ack, in_sda_level});
      if (out_valid && !out_stall)
        sb.check_pins({out_scl_level, out_sda_drive_level, out_sda_enable,
                       out_busy_res, out_done_res, out_rx_byte, out_ack_failed});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(tick_t t);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd_valid <= t.cmd_valid;
    in_func <= t.func;
    in_tx_byte <= t.tx_byte;
    in_send_ack <= t.send_ack;
    in_sda_level <= t.sda_level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [15:0] hp, logic [15:0] rhh, logic [7:0] apl);
    drain();
    apb_write(REG_HALF_PERIOD, {16'd0, hp});
    apb_write(REG_READ_HIGH_HOLD, {16'd0, rhh});
    apb_write(REG_ACK_POLL_LIMIT, {24'd0, apl});
  endtask

  // issue a command, hold it with busy-time commands, then offer an unknown code
  task automatic send_cmd(logic [2:0] f, logic [7:0] txb, logic ack, logic sda, int n);
    tick_t t;
    t = {1'b1, f, txb, ack, sda};
    send_tick(t);
    t.func = FUNC_START;
    repeat (n) begin
      t.tx_byte = 8'($urandom_range(0, 255));
      send_tick(t);
    end
    t.func = FUNC_UNUSED_7;
    send_tick(t);
  endtask

  task automatic run_random(int n, int sda_pct, int hold_at, int pause_at);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      t.cmd_valid = ($urandom_range(0, 99) < 85);
      t.func = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      t.tx_byte = 8'($urandom_range(0, 255));
      t.send_ack = 1'($urandom_range(0, 1));
      t.sda_level = ($urandom_range(0, 99) < sda_pct);
      send_tick(t);
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
    end
  endtask

  initial begin
    tick_t t;
    wait (rst_n);
    @(posedge clk);

    // reset timing values, then retime in the middle of the start
    send_cmd(FUNC_START, 8'h00, 1'b0, 1'b1, 5);
    set_config(16'd1, 16'd1, 8'd0);
    send_cmd(FUNC_UNUSED_6, 8'h00, 1'b0, 1'b0, 1);
    send_cmd(FUNC_START, 8'h00, 1'b0, 1'b1, 2);
    send_cmd(FUNC_WRITE, 8'hFF, 1'b1, 1'b1, 24);
    send_cmd(FUNC_WRITE, 8'h00, 1'b0, 1'b0, 24);
    send_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b0, 3);
    send_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 1'b1, 5);
    send_cmd(FUNC_READ, 8'h00, 1'b1, 1'b1, 18);
    send_cmd(FUNC_READ, 8'hFF, 1'b0, 1'b0, 18);
    send_cmd(FUNC_ACK_BIT, 8'h00, 1'b1, 1'b1, 2);
    send_cmd(FUNC_ACK_BIT, 8'h00, 1'b0, 1'b0, 2);
    send_cmd(FUNC_STOP, 8'h00, 1'b0, 1'b1, 2);

    run_random(300, 50, 100, -1);
    set_config(16'd0, 16'd0, 8'd3);
    run_random(300, 70, -1, 150);
    set_config(16'd2, 16'd3, 8'd255);
    run_random(300, 100, -1, -1);
    set_config(16'd3, 16'd1, 8'd10);
    run_random(300, 85, -1, -1);

    // longest phases: hold a start in its first phase, ignore reads, then retime
    set_config(16'hFFFF, 16'hFFFF, 8'd255);
    t = {1'b1, FUNC_START, 8'h5A, 1'b1, 1'b1};
    send_tick(t);
    t.func = FUNC_READ;
    repeat (64) begin
      t.sda_level = 1'($urandom_range(0, 1));
      send_tick(t);
    end
    set_config(16'd1, 16'd2, 8'd7);
    gaps_on = 1'b0;
    run_random(300, 60, -1, -1);

    drain();
    repeat (10) @(posedge clk);
    if (sb.expected_pins.size() != 0) sb.report("expected transactions left over");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_seq.sv
sv/i2cm_obuf.sv
sv/i2c_master_pin_sequencer.sv
tb/i2c_master_pin_sequencer_test.sv
